### hw/rtl/rpn_pkg.sv
// Package for the postfix stack calculator: token codes, unit opcodes,
// request and result structs, and the control struct of the shared unit.
// No dependencies.
package rpn_pkg;

    localparam int MODE_W = 4;

    // Token codes carried in the mode field of a request.
    localparam logic [MODE_W-1:0] MODE_PUSH = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MUL  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DIV  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_POW  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_LOG  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SQRT = 4'd7;
    localparam logic [MODE_W-1:0] MODE_TERN = 4'd8;
    localparam logic [MODE_W-1:0] MODE_BAD  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_END  = 4'd10;

    // Operations of the shared iterative unit.
    localparam logic [1:0] ALU_MUL  = 2'd0;
    localparam logic [1:0] ALU_DIV  = 2'd1;
    localparam logic [1:0] ALU_SQRT = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_alu_ctl;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic signed [63:0] number;
    } t_rpn_in;

    typedef struct packed {
        logic signed [63:0] answer;
        logic               status;
    } t_rpn_out;

endpackage

### hw/rtl/rpn_stack.sv
// Operand stack storage: one write port and one registered read port.
// Depends on nothing but its parameters.
module rpn_stack #(
    parameter int DEPTH = 64,
    parameter int W     = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [W-1:0]             i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [W-1:0]             o_rd_data
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd_data;

    // The write lands at the edge; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/rpn_alu.sv
// Shared iterative unit: shift-add multiply, restoring divide and
// bit-pair square root around one add/subtract. Uses rpn_pkg.
module rpn_alu import rpn_pkg::*; #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_alu_ctl     i_ctl,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_done,
    output logic [W-1:0] o_lo,
    output logic [W-1:0] o_hi
);

    localparam int CNT_W  = $clog2(W);
    localparam int SQ_POS = 2 * ((W - 1) / 2);

    logic             r_busy;
    logic             r_done;
    logic [1:0]       r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_hi;
    logic [W-1:0]     r_lo;
    logic [W-1:0]     r_opd;
    logic [W-1:0]     r_bit;

    logic [W:0]   add_x;
    logic [W:0]   add_y;
    logic         add_sub;
    logic [W+1:0] sum;
    logic         ge;
    logic         last;

    // Operand selection for the single adder/subtractor.
    always_comb begin
        add_x   = {1'b0, r_hi};
        add_y   = '0;
        add_sub = 1'b0;
        case (r_op)
            ALU_MUL: begin
                add_x = {1'b0, r_hi};
                add_y = r_lo[0] ? {1'b0, r_opd} : '0;
            end
            ALU_DIV: begin
                add_x   = {r_hi, r_lo[W-1]};
                add_y   = {1'b0, r_opd};
                add_sub = 1'b1;
            end
            ALU_SQRT: begin
                // The root never has bits at or below the trial bit, so OR adds.
                add_x   = {1'b0, r_lo};
                add_y   = {1'b0, r_hi | r_bit};
                add_sub = 1'b1;
            end
            default: begin
                add_x = {1'b0, r_hi};
            end
        endcase
        sum  = add_sub ? ({1'b0, add_x} - {1'b0, add_y}) : ({1'b0, add_x} + {1'b0, add_y});
        ge   = ~sum[W+1];
        last = (r_op == ALU_SQRT) ? (r_bit[W-1:2] == '0) : (r_cnt == CNT_W'(W - 1));
    end

    // Control: busy while stepping, one-cycle done pulse after the last step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: load on start, then one step per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op  <= i_ctl.op;
            r_cnt <= '0;
            r_hi  <= '0;
            r_bit <= W'(1) << SQ_POS;
            case (i_ctl.op)
                ALU_MUL: begin
                    r_lo  <= i_b;
                    r_opd <= i_a;
                end
                default: begin
                    r_lo  <= i_a;
                    r_opd <= i_b;
                end
            endcase
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            case (r_op)
                ALU_MUL: begin
                    r_hi <= sum[W:1];
                    r_lo <= {sum[0], r_lo[W-1:1]};
                end
                ALU_DIV: begin
                    r_hi <= ge ? sum[W-1:0] : add_x[W-1:0];
                    r_lo <= {r_lo[W-2:0], ge};
                end
                ALU_SQRT: begin
                    if (ge) begin
                        r_lo <= sum[W-1:0];
                        r_hi <= (r_hi >> 1) | r_bit;
                    end else begin
                        r_hi <= r_hi >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                default: begin
                    r_hi <= r_hi;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_lo   = (r_op == ALU_SQRT) ? r_hi : r_lo;
    assign o_hi   = r_hi;

endmodule

### hw/rtl/rpn_stack_calculator_unit.sv
// Top level of the postfix stack calculator: token sequencer, stack
// storage and the shared iterative unit. Uses rpn_pkg, rpn_stack, rpn_alu.
//
//  Channel   Handshake                 Payload
//  request   start in, busy out        i_request (t_rpn_in)
//  result    o_result_valid strobe     o_result (t_rpn_out)
//
// A push, an ignored token, an error found at acceptance, or an end token on
// an empty or failed line is handled in S_IDLE without raising busy; an end
// token with one entry holds busy through S_END_RD and S_END_OUT. Add and
// subtract hold busy through S_RD1, S_RD2, S_RD3, S_EXEC and S_WB, and ternary
// also through S_RD4, reading operands through the stack memory's single
// registered read port and writing back. Multiply, divide and square root add
// a wait in S_ALU_WAIT on the shared unit; power and log repeat a multiply or
// divide there, once per pass through S_POW_CHK or S_LOG_CHK. Reset is
// synchronous and active low and empties the stack. The result strobe lasts
// one cycle.
module rpn_stack_calculator_unit import rpn_pkg::*; #(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_rpn_in  i_request,
    output logic     o_result_valid,
    output t_rpn_out o_result
);

    localparam int W  = VALUE_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [W-1:0] MAXPOS = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] MINMAG = {1'b1, {(W - 1){1'b0}}};

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD1      = 4'd1;
    localparam logic [3:0] S_RD2      = 4'd2;
    localparam logic [3:0] S_RD3      = 4'd3;
    localparam logic [3:0] S_RD4      = 4'd4;
    localparam logic [3:0] S_EXEC     = 4'd5;
    localparam logic [3:0] S_ALU_WAIT = 4'd6;
    localparam logic [3:0] S_POW_CHK  = 4'd7;
    localparam logic [3:0] S_LOG_CHK  = 4'd8;
    localparam logic [3:0] S_WB       = 4'd9;
    localparam logic [3:0] S_END_RD   = 4'd10;
    localparam logic [3:0] S_END_OUT  = 4'd11;

    logic [3:0]        r_state;
    logic [CW-1:0]     r_cnt;
    logic              r_failed;
    logic [MODE_W-1:0] r_mode;
    logic [1:0]        r_need;
    logic [W-1:0]      r_t;
    logic [W-1:0]      r_s;
    logic [W-1:0]      r_u;
    logic [W-1:0]      r_res;
    logic [W-1:0]      r_mag;
    logic [W-1:0]      r_ex;
    logic              r_pneg;
    logic [W-1:0]      r_x;
    logic [W-1:0]      r_n;
    logic              r_out_valid;
    t_rpn_out          r_out;

    logic              accept;
    logic [1:0]        need;
    logic              s_neg;
    logic              t_neg;
    logic [W-1:0]      mag_s;
    logic [W-1:0]      mag_t;
    logic [W-1:0]      pow_limit;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [W-1:0]      wr_data;
    logic [AW-1:0]     rd_addr;
    logic [W-1:0]      rd_data;
    logic [CW-1:0]     base_idx;
    t_alu_ctl          alu_ctl;
    logic [W-1:0]      alu_a;
    logic [W-1:0]      alu_b;
    logic              alu_done;
    logic [W-1:0]      alu_lo;
    logic [W-1:0]      alu_hi;
    logic signed [W-1:0] end_val;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Operand count per operator.
    always_comb begin
        case (i_request.mode)
            MODE_SQRT: need = 2'd1;
            MODE_TERN: need = 2'd3;
            default:   need = 2'd2;
        endcase
    end

    // Signs and magnitudes of the popped operands.
    assign s_neg     = r_s[W-1];
    assign t_neg     = r_t[W-1];
    assign mag_s     = s_neg ? (W'(0) - r_s) : r_s;
    assign mag_t     = t_neg ? (W'(0) - r_t) : r_t;
    assign pow_limit = r_pneg ? MINMAG : MAXPOS;
    assign base_idx  = r_cnt - CW'(r_need);

    // Stack read address for each read state.
    always_comb begin
        case (r_state)
            S_RD1:   rd_addr = r_cnt[AW-1:0] - AW'(1);
            S_RD2:   rd_addr = r_cnt[AW-1:0] - AW'(2);
            S_RD3:   rd_addr = r_cnt[AW-1:0] - AW'(3);
            default: rd_addr = '0;
        endcase
    end

    // Stack writes: a push from idle, or the operator result at write-back.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cnt[AW-1:0];
        wr_data = i_request.number[W-1:0];
        if (r_state == S_WB) begin
            wr_en   = 1'b1;
            wr_addr = base_idx[AW-1:0];
            wr_data = r_res;
        end else if (accept && !r_failed && i_request.mode == MODE_PUSH
                     && r_cnt < CW'(STACK_DEPTH)) begin
            wr_en = 1'b1;
        end
    end

    // Requests to the shared unit.
    always_comb begin
        alu_ctl.start = 1'b0;
        alu_ctl.op    = ALU_MUL;
        alu_a         = r_s;
        alu_b         = r_t;
        case (r_state)
            S_EXEC: begin
                case (r_mode)
                    MODE_MUL: begin
                        alu_ctl.start = 1'b1;
                    end
                    MODE_DIV: begin
                        alu_ctl.start = (r_t != '0);
                        alu_ctl.op    = ALU_DIV;
                        alu_a         = mag_s;
                        alu_b         = mag_t;
                    end
                    MODE_SQRT: begin
                        alu_ctl.start = !t_neg;
                        alu_ctl.op    = ALU_SQRT;
                        alu_a         = r_t;
                    end
                    default: begin
                        alu_ctl.start = 1'b0;
                    end
                endcase
            end
            S_POW_CHK: begin
                alu_ctl.start = 1'b1;
                alu_a         = r_mag;
                alu_b         = mag_s;
            end
            S_LOG_CHK: begin
                alu_ctl.start = (r_x >= r_t);
                alu_ctl.op    = ALU_DIV;
                alu_a         = r_x;
                alu_b         = r_t;
            end
            default: begin
                alu_ctl.start = 1'b0;
            end
        endcase
    end

    assign end_val = rd_data;

    // Token sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode <= i_request.mode;
                        r_need <= need;
                        if (i_request.mode == MODE_END) begin
                            if (r_failed || r_cnt > CW'(1)) begin
                                r_out_valid   <= 1'b1;
                                r_out.answer  <= '0;
                                r_out.status  <= 1'b1;
                                r_cnt         <= '0;
                                r_failed      <= 1'b0;
                            end else if (r_cnt == CW'(1)) begin
                                r_state <= S_END_RD;
                            end else begin
                                r_out_valid  <= 1'b1;
                                r_out.answer <= '0;
                                r_out.status <= 1'b0;
                            end
                        end else if (r_failed) begin
                            r_failed <= 1'b1;
                        end else if (i_request.mode == MODE_PUSH) begin
                            if (r_cnt < CW'(STACK_DEPTH)) begin
                                r_cnt <= r_cnt + 1'b1;
                            end else begin
                                r_failed <= 1'b1;
                            end
                        end else if (i_request.mode > MODE_TERN) begin
                            r_failed <= 1'b1;
                        end else if (r_cnt < CW'(need)) begin
                            r_failed <= 1'b1;
                        end else begin
                            r_state <= S_RD1;
                        end
                    end
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_t     <= rd_data;
                    r_state <= (r_need == 2'd1) ? S_EXEC : S_RD3;
                end
                S_RD3: begin
                    r_s     <= rd_data;
                    r_state <= (r_need == 2'd2) ? S_EXEC : S_RD4;
                end
                S_RD4: begin
                    r_u     <= rd_data;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    case (r_mode)
                        MODE_ADD: begin
                            r_res   <= r_s + r_t;
                            r_state <= S_WB;
                        end
                        MODE_SUB: begin
                            r_res   <= r_s - r_t;
                            r_state <= S_WB;
                        end
                        MODE_TERN: begin
                            r_res   <= (r_u != '0) ? r_s : r_t;
                            r_state <= S_WB;
                        end
                        MODE_MUL: begin
                            r_state <= S_ALU_WAIT;
                        end
                        MODE_DIV: begin
                            if (r_t == '0) begin
                                r_failed <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_state <= S_ALU_WAIT;
                            end
                        end
                        MODE_SQRT: begin
                            if (t_neg) begin
                                r_failed <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_state <= S_ALU_WAIT;
                            end
                        end
                        MODE_POW: begin
                            r_pneg <= s_neg && r_t[0];
                            if (t_neg) begin
                                r_failed <= 1'b1;
                                r_state  <= S_IDLE;
                            end else if (r_t == '0) begin
                                r_res   <= W'(1);
                                r_state <= S_WB;
                            end else if (mag_s == '0) begin
                                r_res   <= '0;
                                r_state <= S_WB;
                            end else if (mag_s == W'(1)) begin
                                r_res   <= (s_neg && r_t[0]) ? '1 : W'(1);
                                r_state <= S_WB;
                            end else begin
                                r_mag   <= W'(1);
                                r_ex    <= r_t;
                                r_state <= S_POW_CHK;
                            end
                        end
                        MODE_LOG: begin
                            if (t_neg || r_t < W'(2) || s_neg || r_s == '0) begin
                                r_failed <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_x     <= r_s;
                                r_n     <= '0;
                                r_state <= S_LOG_CHK;
                            end
                        end
                        default: begin
                            r_failed <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    endcase
                end
                S_POW_CHK: begin
                    r_state <= S_ALU_WAIT;
                end
                S_LOG_CHK: begin
                    if (r_x >= r_t) begin
                        r_state <= S_ALU_WAIT;
                    end else begin
                        r_res   <= r_n;
                        r_state <= S_WB;
                    end
                end
                S_ALU_WAIT: begin
                    if (alu_done) begin
                        case (r_mode)
                            MODE_DIV: begin
                                r_res   <= (s_neg ^ t_neg) ? (W'(0) - alu_lo) : alu_lo;
                                r_state <= S_WB;
                            end
                            MODE_POW: begin
                                if (alu_hi != '0 || alu_lo > pow_limit) begin
                                    r_failed <= 1'b1;
                                    r_state  <= S_IDLE;
                                end else if (r_ex == W'(1)) begin
                                    r_res   <= r_pneg ? (W'(0) - alu_lo) : alu_lo;
                                    r_state <= S_WB;
                                end else begin
                                    r_mag   <= alu_lo;
                                    r_ex    <= r_ex - 1'b1;
                                    r_state <= S_POW_CHK;
                                end
                            end
                            MODE_LOG: begin
                                r_x     <= alu_lo;
                                r_n     <= r_n + 1'b1;
                                r_state <= S_LOG_CHK;
                            end
                            default: begin
                                r_res   <= alu_lo;
                                r_state <= S_WB;
                            end
                        endcase
                    end
                end
                S_WB: begin
                    r_cnt   <= base_idx + 1'b1;
                    r_state <= S_IDLE;
                end
                S_END_RD: begin
                    r_state <= S_END_OUT;
                end
                S_END_OUT: begin
                    r_out_valid  <= 1'b1;
                    r_out.answer <= 64'(end_val);
                    r_out.status <= 1'b0;
                    r_cnt        <= '0;
                    r_failed     <= 1'b0;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    rpn_stack #(
        .DEPTH (STACK_DEPTH),
        .W     (W)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rpn_alu #(
        .W (W)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (alu_ctl),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_lo    (alu_lo),
        .o_hi    (alu_hi)
    );

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule
